// ===== rtl/tsq_pkg.sv =====
// Shared types and codes of the timestamp-bucketed event queue.
package tsq_pkg;

	typedef logic [2:0] status_t;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_PROCEED = 1'b1;

	localparam status_t ST_INSERTED   = 3'd0;
	localparam status_t ST_LATE       = 3'd1;
	localparam status_t ST_TIMES_FULL = 3'd2;
	localparam status_t ST_SLOT_FULL  = 3'd3;
	localparam status_t ST_DISPATCHED = 3'd4;
	localparam status_t ST_EMPTY      = 3'd5;

	// Port enables from the sequencer to the storage.
	typedef struct packed {
		logic ring_we;
		logic ring_re;
		logic tag_we;
		logic tag_re;
		logic free_we;
		logic free_re;
	} mem_ctl_t;

endpackage

// ===== rtl/tsq_mem.sv =====
// Storage of the event queue: sorted entry ring, tag memory and free-slot FIFO.
module tsq_mem #(
	parameter int MAX_TIMES           = 16,
	parameter int MAX_EVENTS_PER_TIME = 8,
	parameter int TIME_BITS           = 48,
	parameter int TAG_BITS            = 32,
	localparam int SW  = $clog2(MAX_TIMES),
	localparam int EW  = (MAX_EVENTS_PER_TIME > 1) ? $clog2(MAX_EVENTS_PER_TIME) : 1,
	localparam int ECW = $clog2(MAX_EVENTS_PER_TIME + 1),
	localparam int RW  = TIME_BITS + SW + ECW,
	localparam int TAW = SW + EW
) (
	input  logic                clk,
	input  tsq_pkg::mem_ctl_t   mem_ctl,
	input  logic [SW-1:0]       ring_addr,
	input  logic [RW-1:0]       ring_wdata,
	output logic [RW-1:0]       ring_rdata,
	input  logic [TAW-1:0]      tag_addr,
	input  logic [TAG_BITS-1:0] tag_wdata,
	output logic [TAG_BITS-1:0] tag_rdata,
	input  logic [SW-1:0]       free_waddr,
	input  logic [SW-1:0]       free_raddr,
	input  logic [SW-1:0]       free_wdata,
	output logic [SW-1:0]       free_rdata
);

	localparam int TAG_DEPTH = 1 << TAW;

	logic [RW-1:0]       ring_mem [MAX_TIMES];
	logic [TAG_BITS-1:0] tag_mem  [TAG_DEPTH];
	logic [SW-1:0]       free_mem [MAX_TIMES];

	always_ff @(posedge clk) begin
		if (mem_ctl.ring_we) begin
			ring_mem[ring_addr] <= ring_wdata;
		end
		if (mem_ctl.ring_re) begin
			ring_rdata <= ring_mem[ring_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.tag_we) begin
			tag_mem[tag_addr] <= tag_wdata;
		end
		if (mem_ctl.tag_re) begin
			tag_rdata <= tag_mem[tag_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
		if (mem_ctl.free_re) begin
			free_rdata <= free_mem[free_raddr];
		end
	end

endmodule

// ===== rtl/tsq_seq.sv =====
// Sequencer of the event queue with its shared time comparator and result registers.
module tsq_seq #(
	parameter int MAX_TIMES           = 16,
	parameter int MAX_EVENTS_PER_TIME = 8,
	parameter int TIME_BITS           = 48,
	parameter int TAG_BITS            = 32,
	localparam int SW  = $clog2(MAX_TIMES),
	localparam int EW  = (MAX_EVENTS_PER_TIME > 1) ? $clog2(MAX_EVENTS_PER_TIME) : 1,
	localparam int ECW = $clog2(MAX_EVENTS_PER_TIME + 1),
	localparam int RW  = TIME_BITS + SW + ECW,
	localparam int TAW = SW + EW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 operation,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [TAG_BITS-1:0]  event_tag,
	output logic                 busy,
	output logic                 result_valid,
	output tsq_pkg::status_t     status,
	output logic [TAG_BITS-1:0]  out_tag,
	output logic [TIME_BITS-1:0] now_time,
	output logic                 last,
	output logic                 queue_empty,
	output tsq_pkg::mem_ctl_t    mem_ctl,
	output logic [SW-1:0]        ring_addr,
	output logic [RW-1:0]        ring_wdata,
	input  logic [RW-1:0]        ring_rdata,
	output logic [TAW-1:0]       tag_addr,
	output logic [TAG_BITS-1:0]  tag_wdata,
	input  logic [TAG_BITS-1:0]  tag_rdata,
	output logic [SW-1:0]        free_waddr,
	output logic [SW-1:0]        free_raddr,
	output logic [SW-1:0]        free_wdata,
	input  logic [SW-1:0]        free_rdata
);

	localparam int CW  = $clog2(MAX_TIMES + 1);

	localparam logic [CW-1:0]  MAX_T   = CW'(MAX_TIMES);
	localparam logic [CW:0]    MAX_T_W = (CW+1)'(MAX_TIMES);
	localparam logic [SW-1:0]  LAST_SLOT = SW'(MAX_TIMES - 1);
	localparam logic [ECW-1:0] MAX_E   = ECW'(MAX_EVENTS_PER_TIME);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRD   = 3'd1;
	localparam logic [2:0] S_SCMP  = 3'd2;
	localparam logic [2:0] S_NEW   = 3'd3;
	localparam logic [2:0] S_HRD   = 3'd4;
	localparam logic [2:0] S_HWR   = 3'd5;
	localparam logic [2:0] S_PHEAD = 3'd6;
	localparam logic [2:0] S_DISP  = 3'd7;

	logic [2:0]           state_q, state_d;
	logic [TIME_BITS-1:0] time_q, time_d;
	logic [TAG_BITS-1:0]  tag_q, tag_d;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        alloc_q, alloc_d;
	logic [SW-1:0]        head_q, head_d;
	logic [SW-1:0]        fhead_q, fhead_d;
	logic [SW-1:0]        ftail_q, ftail_d;
	logic [CW-1:0]        pos_q, pos_d;
	logic [CW-1:0]        sh_q, sh_d;
	logic [SW-1:0]        slot_q, slot_d;
	logic [ECW-1:0]       cnt_q, cnt_d;
	logic [EW-1:0]        idx_q, idx_d;

	logic                 rv_q, rv_d;
	tsq_pkg::status_t     st_q, st_d;
	logic [TAG_BITS-1:0]  otag_q, otag_d;
	logic                 last_q, last_d;

	logic [TIME_BITS-1:0] cmp_a, cmp_b;
	logic                 cmp_gt, cmp_eq;
	logic [CW-1:0]        ring_idx;
	logic [CW:0]          ring_sum;
	logic [TIME_BITS-1:0] e_time;
	logic [SW-1:0]        e_slot;
	logic [ECW-1:0]       e_cnt;
	logic [SW-1:0]        new_slot;
	logic                 disp_last;

	assign e_time = ring_rdata[RW-1 -: TIME_BITS];
	assign e_slot = ring_rdata[ECW +: SW];
	assign e_cnt  = ring_rdata[ECW-1:0];

	// The one magnitude comparator, shared by the late check and the table scan.
	assign cmp_gt = cmp_a > cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	// Logical table positions are offsets from the ring head.
	always_comb begin
		ring_sum = (CW+1)'(head_q) + (CW+1)'(ring_idx);
		if (ring_sum >= MAX_T_W) begin
			ring_addr = SW'(ring_sum - MAX_T_W);
		end else begin
			ring_addr = SW'(ring_sum);
		end
	end

	assign new_slot  = (alloc_q < MAX_T) ? alloc_q[SW-1:0] : free_rdata;
	assign disp_last = (ECW'(idx_q) + ECW'(1)) == cnt_q;
	assign free_waddr = ftail_q;
	assign free_raddr = fhead_q;
	assign free_wdata = e_slot;

	always_comb begin
		state_d    = state_q;
		time_d     = time_q;
		tag_d      = tag_q;
		now_d      = now_q;
		count_d    = count_q;
		alloc_d    = alloc_q;
		head_d     = head_q;
		fhead_d    = fhead_q;
		ftail_d    = ftail_q;
		pos_d      = pos_q;
		sh_d       = sh_q;
		slot_d     = slot_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		rv_d       = 1'b0;
		st_d       = st_q;
		otag_d     = otag_q;
		last_d     = last_q;
		mem_ctl    = '0;
		ring_idx   = pos_q;
		ring_wdata = {time_q, slot_q, cnt_q};
		tag_addr   = {slot_q, idx_q};
		tag_wdata  = tag_q;
		cmp_a      = e_time;
		cmp_b      = time_q;

		case (state_q)
			S_IDLE: begin
				ring_idx = '0;
				cmp_a    = event_time;
				cmp_b    = now_q;
				if (start) begin
					time_d = event_time;
					tag_d  = event_tag;
					pos_d  = '0;
					if (operation == tsq_pkg::OP_PROCEED) begin
						if (count_q == '0) begin
							rv_d   = 1'b1;
							st_d   = tsq_pkg::ST_EMPTY;
							otag_d = '0;
							last_d = 1'b1;
						end else begin
							mem_ctl.ring_re = 1'b1;
							state_d = S_PHEAD;
						end
					end else if (!cmp_gt) begin
						rv_d   = 1'b1;
						st_d   = tsq_pkg::ST_LATE;
						otag_d = '0;
						last_d = 1'b1;
					end else begin
						// Fetch a recycled slot now in case a new entry is opened.
						mem_ctl.free_re = 1'b1;
						state_d = S_SRD;
					end
				end
			end
			S_SRD: begin
				if (pos_q == count_q) begin
					state_d = S_NEW;
				end else begin
					mem_ctl.ring_re = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				if (cmp_eq) begin
					rv_d    = 1'b1;
					otag_d  = '0;
					last_d  = 1'b1;
					state_d = S_IDLE;
					if (e_cnt == MAX_E) begin
						st_d = tsq_pkg::ST_SLOT_FULL;
					end else begin
						st_d            = tsq_pkg::ST_INSERTED;
						mem_ctl.tag_we  = 1'b1;
						tag_addr        = {e_slot, e_cnt[EW-1:0]};
						mem_ctl.ring_we = 1'b1;
						ring_wdata      = {time_q, e_slot, e_cnt + ECW'(1)};
					end
				end else if (cmp_gt) begin
					state_d = S_NEW;
				end else begin
					pos_d   = pos_q + CW'(1);
					state_d = S_SRD;
				end
			end
			S_NEW: begin
				if (count_q == MAX_T) begin
					rv_d    = 1'b1;
					st_d    = tsq_pkg::ST_TIMES_FULL;
					otag_d  = '0;
					last_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					sh_d    = count_q;
					state_d = S_HRD;
				end
			end
			S_HRD: begin
				if (sh_q == pos_q) begin
					mem_ctl.ring_we = 1'b1;
					ring_wdata      = {time_q, new_slot, ECW'(1)};
					mem_ctl.tag_we  = 1'b1;
					tag_addr        = {new_slot, EW'(0)};
					count_d         = count_q + CW'(1);
					if (alloc_q < MAX_T) begin
						alloc_d = alloc_q + CW'(1);
					end else begin
						fhead_d = (fhead_q == LAST_SLOT) ? '0 : fhead_q + SW'(1);
					end
					rv_d    = 1'b1;
					st_d    = tsq_pkg::ST_INSERTED;
					otag_d  = '0;
					last_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					ring_idx        = sh_q - CW'(1);
					mem_ctl.ring_re = 1'b1;
					state_d         = S_HWR;
				end
			end
			S_HWR: begin
				// Move the entry just read one place toward the tail.
				ring_idx        = sh_q;
				ring_wdata      = ring_rdata;
				mem_ctl.ring_we = 1'b1;
				sh_d            = sh_q - CW'(1);
				state_d         = S_HRD;
			end
			S_PHEAD: begin
				now_d           = e_time;
				slot_d          = e_slot;
				cnt_d           = e_cnt;
				head_d          = (head_q == LAST_SLOT) ? '0 : head_q + SW'(1);
				count_d         = count_q - CW'(1);
				mem_ctl.free_we = 1'b1;
				ftail_d         = (ftail_q == LAST_SLOT) ? '0 : ftail_q + SW'(1);
				idx_d           = '0;
				mem_ctl.tag_re  = 1'b1;
				tag_addr        = {e_slot, EW'(0)};
				state_d         = S_DISP;
			end
			S_DISP: begin
				rv_d   = 1'b1;
				st_d   = tsq_pkg::ST_DISPATCHED;
				otag_d = tag_rdata;
				last_d = disp_last;
				if (disp_last) begin
					state_d = S_IDLE;
				end else begin
					idx_d          = idx_q + EW'(1);
					mem_ctl.tag_re = 1'b1;
					tag_addr       = {slot_q, idx_q + EW'(1)};
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q   <= '0;
			count_q <= '0;
			alloc_q <= '0;
			head_q  <= '0;
			fhead_q <= '0;
			ftail_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			now_q   <= now_d;
			count_q <= count_d;
			alloc_q <= alloc_d;
			head_q  <= head_d;
			fhead_q <= fhead_d;
			ftail_q <= ftail_d;
			rv_q    <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		time_q <= time_d;
		tag_q  <= tag_d;
		pos_q  <= pos_d;
		sh_q   <= sh_d;
		slot_q <= slot_d;
		cnt_q  <= cnt_d;
		idx_q  <= idx_d;
		st_q   <= st_d;
		otag_q <= otag_d;
		last_q <= last_d;
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = rv_q;
	assign status       = st_q;
	assign out_tag      = otag_q;
	assign last         = last_q;
	assign now_time     = now_q;
	assign queue_empty  = count_q == '0;

endmodule

// ===== rtl/timestamp_bucketed_event_queue.sv =====
// Timestamp-bucketed event queue: top level joining the sequencer and the storage.
// Inserts scan the single-port entry ring for the event time and, for a new time, move each later
// entry one place toward the tail before writing the new entry; a tag joining an existing entry
// answers once the scan reaches it. A late insert or an empty proceed answers straight from idle;
// a proceed reads the head entry and then its first tag, then gives one tag per cycle.
// The next transaction is taken in the cycle of the final result; reset clears control state only.
module timestamp_bucketed_event_queue #(
	parameter int MAX_TIMES           = 16,
	parameter int MAX_EVENTS_PER_TIME = 8,
	parameter int TIME_BITS           = 48,
	parameter int TAG_BITS            = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 operation,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic [TAG_BITS-1:0]  event_tag,
	output logic                 result_valid,
	output logic [2:0]           status,
	output logic [TAG_BITS-1:0]  out_tag,
	output logic [TIME_BITS-1:0] now_time,
	output logic                 last,
	output logic                 queue_empty
);

	localparam int SW  = $clog2(MAX_TIMES);
	localparam int EW  = (MAX_EVENTS_PER_TIME > 1) ? $clog2(MAX_EVENTS_PER_TIME) : 1;
	localparam int ECW = $clog2(MAX_EVENTS_PER_TIME + 1);
	localparam int RW  = TIME_BITS + SW + ECW;
	localparam int TAW = SW + EW;

	tsq_pkg::mem_ctl_t   mem_ctl;
	logic [SW-1:0]       ring_addr;
	logic [RW-1:0]       ring_wdata;
	logic [RW-1:0]       ring_rdata;
	logic [TAW-1:0]      tag_addr;
	logic [TAG_BITS-1:0] tag_wdata;
	logic [TAG_BITS-1:0] tag_rdata;
	logic [SW-1:0]       free_waddr;
	logic [SW-1:0]       free_raddr;
	logic [SW-1:0]       free_wdata;
	logic [SW-1:0]       free_rdata;

	tsq_seq #(
		.MAX_TIMES          (MAX_TIMES),
		.MAX_EVENTS_PER_TIME(MAX_EVENTS_PER_TIME),
		.TIME_BITS          (TIME_BITS),
		.TAG_BITS           (TAG_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.operation   (operation),
		.event_time  (event_time),
		.event_tag   (event_tag),
		.busy        (busy),
		.result_valid(result_valid),
		.status      (status),
		.out_tag     (out_tag),
		.now_time    (now_time),
		.last        (last),
		.queue_empty (queue_empty),
		.mem_ctl     (mem_ctl),
		.ring_addr   (ring_addr),
		.ring_wdata  (ring_wdata),
		.ring_rdata  (ring_rdata),
		.tag_addr    (tag_addr),
		.tag_wdata   (tag_wdata),
		.tag_rdata   (tag_rdata),
		.free_waddr  (free_waddr),
		.free_raddr  (free_raddr),
		.free_wdata  (free_wdata),
		.free_rdata  (free_rdata)
	);

	tsq_mem #(
		.MAX_TIMES          (MAX_TIMES),
		.MAX_EVENTS_PER_TIME(MAX_EVENTS_PER_TIME),
		.TIME_BITS          (TIME_BITS),
		.TAG_BITS           (TAG_BITS)
	) u_mem (
		.clk       (clk),
		.mem_ctl   (mem_ctl),
		.ring_addr (ring_addr),
		.ring_wdata(ring_wdata),
		.ring_rdata(ring_rdata),
		.tag_addr  (tag_addr),
		.tag_wdata (tag_wdata),
		.tag_rdata (tag_rdata),
		.free_waddr(free_waddr),
		.free_raddr(free_raddr),
		.free_wdata(free_wdata),
		.free_rdata(free_rdata)
	);

endmodule

// ===== rtl/tsq_chk.sv =====
// Port-level checks of the event queue and their binding to the top level.
module tsq_chk #(
	parameter int TAG_BITS  = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 result_valid,
	input logic [2:0]           status,
	input logic [TAG_BITS-1:0]  out_tag,
	input logic                 last,
	input logic                 queue_empty
);

	// A dispatch burst has no gaps until its final tag.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && status == tsq_pkg::ST_DISPATCHED)
		else $error("dispatch burst broken before its last tag");

	// Every accepted transaction either keeps the block working or answers at once.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || result_valid)
		else $error("accepted transaction produced neither work nor result");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != tsq_pkg::ST_DISPATCHED |-> last && out_tag == '0)
		else $error("non-dispatch result must be a single last result with zero tag");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == tsq_pkg::ST_EMPTY |-> queue_empty)
		else $error("empty report while entries remain");

	a_inserted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == tsq_pkg::ST_INSERTED |-> !queue_empty)
		else $error("queue shows empty right after an insert");

endmodule

bind timestamp_bucketed_event_queue tsq_chk #(
	.TAG_BITS (TAG_BITS)
) u_tsq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.status      (status),
	.out_tag     (out_tag),
	.last        (last),
	.queue_empty (queue_empty)
);

// ===== sim/tb.sv =====
// Testbench for the timestamp-bucketed event queue: directed and random traffic with a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_TIMES           = 16;
	localparam int MAX_EVENTS_PER_TIME = 8;
	localparam int TIME_W              = 48;
	localparam int TAG_W               = 32;
	localparam int RANDOM_ITEMS        = 330;
	localparam int QUIET_LIMIT         = 2000;
	localparam int TAIL_CYCLES         = 40;

	typedef struct {
		tsq_pkg::status_t  status;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] now;
		logic              last;
		logic              empty;
	} report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              operation = tsq_pkg::OP_INSERT;
	logic [TIME_W-1:0] event_time = '0;
	logic [TAG_W-1:0]  event_tag = '0;
	logic              result_valid;
	logic [2:0]        status;
	logic [TAG_W-1:0]  out_tag;
	logic [TIME_W-1:0] now_time;
	logic              last;
	logic              queue_empty;

	// Predicted schedule: ascending bucket times, each with its FIFO of tags.
	logic [TIME_W-1:0] bucket_time [MAX_TIMES];
	int                bucket_fill [MAX_TIMES];
	logic [TAG_W-1:0]  bucket_tag  [MAX_TIMES][MAX_EVENTS_PER_TIME];
	int                live_entries = 0;
	logic [TIME_W-1:0] now_tick = '0;

	report_t pending_reports[$];
	int      error_count = 0;
	int      quiet_cycles = 0;
	bit      idle_off = 1'b0;

	timestamp_bucketed_event_queue #(
		.MAX_TIMES          (MAX_TIMES),
		.MAX_EVENTS_PER_TIME(MAX_EVENTS_PER_TIME),
		.TIME_BITS          (TIME_W),
		.TAG_BITS           (TAG_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.event_time  (event_time),
		.event_tag   (event_tag),
		.result_valid(result_valid),
		.status      (status),
		.out_tag     (out_tag),
		.now_time    (now_time),
		.last        (last),
		.queue_empty (queue_empty)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void push_report(tsq_pkg::status_t st, logic [TAG_W-1:0] tag, logic fin);
		report_t r;
		r.status = st;
		r.tag    = tag;
		r.now    = now_tick;
		r.last   = fin;
		r.empty  = (live_entries == 0);
		pending_reports.push_back(r);
	endfunction

	function automatic void apply_to_schedule(logic op, logic [TIME_W-1:0] t,
			logic [TAG_W-1:0] tag);
		tsq_pkg::status_t st;
		int               pos;
		int               i;
		int               cnt;
		logic [TAG_W-1:0] head_tags [MAX_EVENTS_PER_TIME];
		if (op == tsq_pkg::OP_INSERT) begin
			st = tsq_pkg::ST_INSERTED;
			if (t <= now_tick) begin
				st = tsq_pkg::ST_LATE;
			end else begin
				pos = 0;
				while (pos < live_entries && bucket_time[pos] < t)
					pos++;
				if (pos < live_entries && bucket_time[pos] == t) begin
					if (bucket_fill[pos] >= MAX_EVENTS_PER_TIME) begin
						st = tsq_pkg::ST_SLOT_FULL;
					end else begin
						bucket_tag[pos][bucket_fill[pos]] = tag;
						bucket_fill[pos]++;
					end
				end else if (live_entries >= MAX_TIMES) begin
					st = tsq_pkg::ST_TIMES_FULL;
				end else begin
					for (i = live_entries; i > pos; i--) begin
						bucket_time[i] = bucket_time[i-1];
						bucket_fill[i] = bucket_fill[i-1];
						bucket_tag[i]  = bucket_tag[i-1];
					end
					bucket_time[pos]   = t;
					bucket_fill[pos]   = 1;
					bucket_tag[pos][0] = tag;
					live_entries++;
				end
			end
			push_report(st, '0, 1'b1);
		end else if (live_entries == 0) begin
			push_report(tsq_pkg::ST_EMPTY, '0, 1'b1);
		end else begin
			now_tick  = bucket_time[0];
			cnt       = bucket_fill[0];
			head_tags = bucket_tag[0];
			for (i = 0; i < live_entries - 1; i++) begin
				bucket_time[i] = bucket_time[i+1];
				bucket_fill[i] = bucket_fill[i+1];
				bucket_tag[i]  = bucket_tag[i+1];
			end
			live_entries--;
			for (i = 0; i < cnt; i++)
				push_report(tsq_pkg::ST_DISPATCHED, head_tags[i], i == cnt - 1);
		end
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Start stays high across back-to-back transactions; it only drops for a gap.
	task automatic send_item(input logic op, input logic [TIME_W-1:0] t,
			input logic [TAG_W-1:0] tag);
		int gap;
		gap = idle_off ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		event_time <= t;
		event_tag  <= tag;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_to_schedule(op, t, tag);
	endtask

	task automatic test_empty_and_late();
		send_item(tsq_pkg::OP_PROCEED, '1, '1);
		send_item(tsq_pkg::OP_INSERT, '0, '1);
		send_item(tsq_pkg::OP_INSERT, 48'd5, 32'hA5A5_0001);
		send_item(tsq_pkg::OP_PROCEED, '0, '0);
		send_item(tsq_pkg::OP_INSERT, 48'd5, 32'hA5A5_0002);
		send_item(tsq_pkg::OP_INSERT, 48'd3, 32'hA5A5_0003);
		send_item(tsq_pkg::OP_PROCEED, '0, '0);
	endtask

	task automatic test_sorted_placement();
		send_item(tsq_pkg::OP_INSERT, 48'd40, 32'h0000_0040);
		send_item(tsq_pkg::OP_INSERT, 48'd20, 32'h0000_0020);
		send_item(tsq_pkg::OP_INSERT, 48'd30, 32'h0000_0030);
		send_item(tsq_pkg::OP_INSERT, 48'd20, 32'h0000_0000);
		send_item(tsq_pkg::OP_INSERT, 48'd10, 32'hFFFF_FFFF);
		repeat (4) send_item(tsq_pkg::OP_PROCEED, '0, '0);
	endtask

	task automatic test_slot_overflow();
		int i;
		for (i = 0; i <= MAX_EVENTS_PER_TIME; i++)
			send_item(tsq_pkg::OP_INSERT, 48'd100, $urandom);
		send_item(tsq_pkg::OP_PROCEED, '0, '0);
	endtask

	// Alternating fill and drain phases push the table to full and back to empty.
	task automatic test_random_traffic();
		int                n;
		int                pick;
		bit                filling;
		logic [63:0]       r;
		logic [TIME_W-1:0] t;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			filling  = ((n / 40) % 2) == 0;
			idle_off = ((n / 40) % 4) == 3;
			r        = {$urandom, $urandom};
			if ($urandom_range(0, 99) < (filling ? 8 : 55)) begin
				send_item(tsq_pkg::OP_PROCEED, r[TIME_W-1:0], r[63:32]);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40 && live_entries > 0) begin
					t = bucket_time[$urandom_range(0, live_entries - 1)];
				end else if (pick < 50) begin
					t = TIME_W'($urandom_range(0, 3));
					t = (now_tick > t) ? now_tick - t : '0;
				end else if (pick < 90) begin
					t = now_tick + TIME_W'($urandom_range(1, 24));
				end else begin
					t = now_tick + TIME_W'($urandom);
				end
				send_item(tsq_pkg::OP_INSERT, t, r[63:32]);
			end
		end
		idle_off = 1'b0;
	endtask

	// Runs last: once time reaches the top of its range every insert is late.
	task automatic test_time_ceiling();
		while (live_entries > 0)
			send_item(tsq_pkg::OP_PROCEED, '0, '0);
		send_item(tsq_pkg::OP_INSERT, '1, '1);
		send_item(tsq_pkg::OP_INSERT, 48'h8000_0000_0000, 32'h8000_0000);
		send_item(tsq_pkg::OP_INSERT, '1, '0);
		send_item(tsq_pkg::OP_PROCEED, '0, '0);
		send_item(tsq_pkg::OP_PROCEED, '0, '0);
		send_item(tsq_pkg::OP_INSERT, '1, 32'h1234_5678);
		send_item(tsq_pkg::OP_PROCEED, '1, '1);
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		report_t want;
		if (arst_n && result_valid) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: status %0d, out_tag %0h", status, out_tag);
				error_count++;
			end else begin
				want = pending_reports[0];
				pending_reports.delete(0);
				check_field("status", want.status, status);
				check_field("out_tag", want.tag, out_tag);
				check_field("now_time", want.now, now_time);
				check_field("last", want.last, last);
				check_field("queue_empty", want.empty, queue_empty);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_late();
		test_sorted_placement();
		test_slot_overflow();
		test_random_traffic();
		test_time_ceiling();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
